// File: hw/rtl/swr_pkg.sv
// shared constants and types for the square window rotate block
// no dependencies
`default_nettype none

package swr_pkg;

    localparam int MAX_DIM_DEF   = 64;
    localparam int WORD_BITS_DEF = 16;
    localparam int DIM_W         = 7;

    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_ROTATE = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    localparam logic ST_DONE    = 1'b0;
    localparam logic ST_REFUSED = 1'b1;

    typedef struct packed {
        logic en;
        logic we;
    } t_mem_ctl;

    typedef struct packed {
        logic done;
        logic status;
    } t_result_flags;

endpackage

`default_nettype wire

// File: hw/rtl/swr_ram.sv
// generic single-port ram with registered read data
// no dependencies
`default_nettype none

module swr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_en) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/swr_seq.sv
// request sequencer: cell access and in-place window rotation by four-way cycles
// depends on swr_pkg; drives the cell ram
`default_nettype none

module swr_seq
    import swr_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int ADDR_W    = $clog2(MAX_DIM * MAX_DIM)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire logic [1:0]           i_action,
    input  wire logic [DIM_W-1:0]     i_row,
    input  wire logic [DIM_W-1:0]     i_col,
    input  wire logic [4:0]           i_radius,
    input  wire logic                 i_direction,
    input  wire logic [WORD_BITS-1:0] i_write_value,
    input  wire logic [DIM_W-1:0]     i_dim,
    output t_mem_ctl                  o_mem_ctl,
    output logic      [ADDR_W-1:0]    o_mem_addr,
    output logic      [WORD_BITS-1:0] o_mem_wdata,
    input  wire logic [WORD_BITS-1:0] i_mem_rdata,
    output t_result_flags             o_result,
    output logic      [WORD_BITS-1:0] o_read_value
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_ROT  = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic                 r_done, n_done;
    logic                 r_status, n_status;
    logic [WORD_BITS-1:0] r_rd, n_rd;
    logic [DIM_W-1:0]     r_top, n_top;
    logic [DIM_W-1:0]     r_left, n_left;
    logic [5:0]           r_last, n_last;
    logic [5:0]           r_i, n_i;
    logic [5:0]           r_j, n_j;
    logic [2:0]           r_phase, n_phase;
    logic                 r_dir, n_dir;
    logic [4:0]           r_rad, n_rad;
    logic [WORD_BITS-1:0] r_v [4];
    logic [WORD_BITS-1:0] n_v [4];

    logic             cell_ok, win_ok;
    logic [1:0]       corner, src;
    logic [5:0]       rel_r, rel_c;
    logic [DIM_W-1:0] abs_r, abs_c;
    logic             go;

    assign go = i_start && (r_state == S_IDLE);

    assign cell_ok = (i_row != '0) && (i_row <= i_dim) && (i_col != '0) && (i_col <= i_dim);
    assign win_ok  = ({1'b0, i_row} >= 8'd1 + 8'(i_radius))
                  && ({1'b0, i_row} + 8'(i_radius) <= {1'b0, i_dim})
                  && ({1'b0, i_col} >= 8'd1 + 8'(i_radius))
                  && ({1'b0, i_col} + 8'(i_radius) <= {1'b0, i_dim});

    // reads walk corners 0..3, writes go to corner m (cw) or m+1 (ccw)
    assign corner = r_phase[2] ? (r_phase[1:0] + {1'b0, r_dir}) : r_phase[1:0];
    assign src    = r_phase[1:0] + {1'b0, ~r_dir};

    always_comb begin
        case (corner)
            2'd0: begin
                rel_r = r_i;
                rel_c = r_j;
            end
            2'd1: begin
                rel_r = r_last - r_j;
                rel_c = r_i;
            end
            2'd2: begin
                rel_r = r_last - r_i;
                rel_c = r_last - r_j;
            end
            default: begin
                rel_r = r_j;
                rel_c = r_last - r_i;
            end
        endcase
        if (r_state == S_ROT) begin
            abs_r = r_top + DIM_W'(rel_r);
            abs_c = r_left + DIM_W'(rel_c);
        end else begin
            abs_r = i_row - 1'b1;
            abs_c = i_col - 1'b1;
        end
    end

    assign o_mem_addr = ADDR_W'(ADDR_W'(abs_r) * ADDR_W'(MAX_DIM)) + ADDR_W'(abs_c);

    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_status = r_status;
        n_rd     = r_rd;
        n_top    = r_top;
        n_left   = r_left;
        n_last   = r_last;
        n_i      = r_i;
        n_j      = r_j;
        n_phase  = r_phase;
        n_dir    = r_dir;
        n_rad    = r_rad;
        n_v      = r_v;
        o_mem_ctl   = '0;
        o_mem_wdata = i_write_value;
        case (r_state)
            S_IDLE: begin
                if (go) begin
                    case (i_action)
                        ACT_WRITE: begin
                            o_mem_ctl.en = cell_ok;
                            o_mem_ctl.we = cell_ok;
                            n_done   = 1'b1;
                            n_status = cell_ok ? ST_DONE : ST_REFUSED;
                            n_rd     = '0;
                        end
                        ACT_READ: begin
                            if (cell_ok) begin
                                o_mem_ctl.en = 1'b1;
                                n_state      = S_READ;
                            end else begin
                                n_done   = 1'b1;
                                n_status = ST_REFUSED;
                                n_rd     = '0;
                            end
                        end
                        ACT_ROTATE: begin
                            if (win_ok && (i_radius != '0)) begin
                                n_state = S_ROT;
                                n_top   = i_row - 1'b1 - DIM_W'(i_radius);
                                n_left  = i_col - 1'b1 - DIM_W'(i_radius);
                                n_last  = {i_radius, 1'b0};
                                n_rad   = i_radius;
                                n_dir   = i_direction;
                                n_i     = '0;
                                n_j     = '0;
                                n_phase = '0;
                            end else begin
                                n_done   = 1'b1;
                                n_status = win_ok ? ST_DONE : ST_REFUSED;
                                n_rd     = '0;
                            end
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = ST_REFUSED;
                            n_rd     = '0;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_done   = 1'b1;
                n_status = ST_DONE;
                n_rd     = i_mem_rdata;
                n_state  = S_IDLE;
            end
            S_ROT: begin
                o_mem_ctl.en = 1'b1;
                o_mem_ctl.we = r_phase[2];
                o_mem_wdata  = r_v[src];
                if ((r_phase != 3'd0) && (r_phase <= 3'd4)) begin
                    n_v[2'(r_phase - 3'd1)] = i_mem_rdata;
                end
                n_phase = r_phase + 3'd1;
                if (r_phase == 3'd7) begin
                    if (r_j == r_last - 6'd1 - r_i) begin
                        if (r_i == 6'(r_rad) - 6'd1) begin
                            n_state  = S_IDLE;
                            n_done   = 1'b1;
                            n_status = ST_DONE;
                            n_rd     = '0;
                        end
                        n_i = r_i + 6'd1;
                        n_j = r_i + 6'd1;
                    end else begin
                        n_j = r_j + 6'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_status <= n_status;
        r_rd     <= n_rd;
        r_top    <= n_top;
        r_left   <= n_left;
        r_last   <= n_last;
        r_i      <= n_i;
        r_j      <= n_j;
        r_phase  <= n_phase;
        r_dir    <= n_dir;
        r_rad    <= n_rad;
        r_v      <= n_v;
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_result.done   = r_done;
    assign o_result.status = r_status;
    assign o_read_value    = r_rd;

endmodule

`default_nettype wire

// File: hw/rtl/square_window_rotate_90_top.sv
// top level: apb dimension register, request sequencer and cell ram
// depends on swr_pkg, swr_seq, swr_ram
//
// A request is taken when start is high and busy is low; its one result is flagged by
// o_done high for exactly one cycle and cannot be stalled; o_status/o_read_value hold it
// until the next result. A write or a refused request answers in the cycle after it is taken,
// a read after the read state captures the registered ram data. A rotation of radius r walks
// r*(r+1) four-cell cycles, each four reads and four writes through the single ram port, with
// busy high throughout. Cells are undefined until written; there is no clearing pass.
`default_nettype none

module square_window_rotate_90_top
    import swr_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           i_action,
    input  wire logic [DIM_W-1:0]     i_row,
    input  wire logic [DIM_W-1:0]     i_col,
    input  wire logic [4:0]           i_radius,
    input  wire logic                 i_direction,
    input  wire logic [WORD_BITS-1:0] i_write_value,
    output logic                      o_done,
    output logic      [WORD_BITS-1:0] o_read_value,
    output logic                      o_status
);

    localparam int ADDR_W    = $clog2(MAX_DIM * MAX_DIM);
    localparam int DIM_RESET = (MAX_DIM < 64) ? MAX_DIM : 64;

    logic [DIM_W-1:0]     r_dim, n_dim;
    logic                 cfg_wr;
    t_mem_ctl             mem_ctl;
    logic [ADDR_W-1:0]    mem_addr;
    logic [WORD_BITS-1:0] mem_wdata, mem_rdata;
    t_result_flags        result;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];

    // saturate to 1..MAX_DIM
    always_comb begin
        n_dim = r_dim;
        if (cfg_wr) begin
            if (pwdata[DIM_W-1:0] == '0) begin
                n_dim = DIM_W'(1);
            end else if (9'(pwdata[DIM_W-1:0]) > 9'(MAX_DIM)) begin
                n_dim = DIM_W'(MAX_DIM);
            end else begin
                n_dim = pwdata[DIM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= DIM_W'(DIM_RESET);
        end else begin
            r_dim <= n_dim;
        end
    end

    assign prdata = paddr[2] ? 32'd0 : 32'(r_dim);

    swr_seq #(
        .MAX_DIM   (MAX_DIM),
        .WORD_BITS (WORD_BITS),
        .ADDR_W    (ADDR_W)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_action      (i_action),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_radius      (i_radius),
        .i_direction   (i_direction),
        .i_write_value (i_write_value),
        .i_dim         (r_dim),
        .o_mem_ctl     (mem_ctl),
        .o_mem_addr    (mem_addr),
        .o_mem_wdata   (mem_wdata),
        .i_mem_rdata   (mem_rdata),
        .o_result      (result),
        .o_read_value  (o_read_value)
    );

    swr_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAX_DIM * MAX_DIM)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (mem_ctl.en),
        .i_we    (mem_ctl.we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign o_done   = result.done;
    assign o_status = result.status;

endmodule

`default_nettype wire
